[src/pbmt_pkg.sv]
// ----------------------------------------------------------------------------
// pbmt_pkg
// Shared types and constants for the pointer bounds metadata table.
// ----------------------------------------------------------------------------
package pbmt_pkg;

	localparam int SLOT_SHIFT     = 3;
	localparam int SEC_INDEX_BITS = 10;
	localparam int PRI_INDEX_BITS = 6;
	localparam int POOL_TABLES    = 8;
	localparam int ADDR_BITS      = 32;

	localparam int LOC_BITS       = SLOT_SHIFT + SEC_INDEX_BITS + PRI_INDEX_BITS;
	localparam int PRI_ENTRIES    = 1 << PRI_INDEX_BITS;
	localparam int SEC_ENTRIES    = 1 << SEC_INDEX_BITS;
	localparam int TBL_BITS       = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
	localparam int USED_BITS      = $clog2(POOL_TABLES + 1);
	localparam int META_DEPTH     = POOL_TABLES * SEC_ENTRIES;
	localparam int META_ADDR_BITS = $clog2(META_DEPTH);
	localparam int SIZE_BITS      = 16;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_LOAD  = 2'd1,
		OP_CHECK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_UNMAPPED   = 2'd1,
		ST_POOL_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]           op;
		logic [LOC_BITS-1:0]  location;
		logic [ADDR_BITS-1:0] lower_bound;
		logic [ADDR_BITS-1:0] upper_bound;
		logic [ADDR_BITS-1:0] pointer;
		logic [SIZE_BITS-1:0] access_size;
	} req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] found_lower;
		logic [ADDR_BITS-1:0] found_upper;
		logic [1:0]           status;
		logic                 in_bounds;
	} rsp_t;

endpackage

[src/pbmt_req_if.sv]
// ----------------------------------------------------------------------------
// pbmt_req_if
// Request channel: valid/ready handshake carrying one metadata operation.
// ----------------------------------------------------------------------------
interface pbmt_req_if;
	import pbmt_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[src/pbmt_rsp_if.sv]
// ----------------------------------------------------------------------------
// pbmt_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface pbmt_rsp_if;
	import pbmt_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[src/pointer_bounds_metadata_table.sv]
// ----------------------------------------------------------------------------
// pointer_bounds_metadata_table
// Two-level trie of base/bound metadata per pointer slot, with bounds check.
// ----------------------------------------------------------------------------
// After reset the block sweeps all META_DEPTH (8192) entries of the metadata
// memory to zero, one entry per cycle; req.ready stays low during the sweep.
// Then each operation goes from transfer to result in these steps: the
// transfer edge reads the primary memory, the lookup cycle resolves the
// mapping (allocating a pool table on a first store) and issues the
// metadata read or write, and the finish cycle loads the result register.
// The block takes no new request before the last one has finished, a pace
// set by the two memory reads in series. A result waiting in the output
// register does not block the next request; only the finish step holds
// until the output register is free.
// Store (op 0) maps the primary entry if needed and writes the pair; it
// returns status 2 and writes nothing when the pool is exhausted. Load (op 1)
// returns the stored pair, or zeros with status 1 for an unmapped primary
// entry. Check (op 2) reports in_bounds when pointer >= lower_bound and
// pointer + access_size < upper_bound, with no wrap. Op 3 returns all zeros.
// ----------------------------------------------------------------------------
module pointer_bounds_metadata_table (
	input  logic       clk,
	input  logic       arst_n,
	pbmt_req_if.sink   req,
	pbmt_rsp_if.source rsp
);
	import pbmt_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic [META_ADDR_BITS-1:0] clr_cnt_q;
	logic [USED_BITS-1:0]      tables_used_q;
	logic [PRI_ENTRIES-1:0]    pri_valid_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_data_q;

	// Captured request and per-item working registers
	req_t                      item_q;
	logic [1:0]                status_q;
	logic                      ge_lo_q;
	logic [ADDR_BITS:0]        diff_q;

	// Memories: primary table numbers and base/bound pairs
	logic [TBL_BITS-1:0]       pri_mem [PRI_ENTRIES];
	logic [TBL_BITS-1:0]       pri_rd_q;
	logic [2*ADDR_BITS-1:0]    meta_mem [META_DEPTH];
	logic [2*ADDR_BITS-1:0]    meta_rd_q;

	logic                      req_xfer;
	logic [PRI_INDEX_BITS-1:0] req_pri;
	logic [PRI_INDEX_BITS-1:0] pri;
	logic [SEC_INDEX_BITS-1:0] sec;
	logic                      mapped;
	logic                      pool_free;
	logic                      is_store;
	logic                      alloc;
	logic [TBL_BITS-1:0]       tbl;
	logic                      meta_we;
	logic                      meta_re;
	logic [META_ADDR_BITS-1:0] meta_addr;
	logic [2*ADDR_BITS-1:0]    meta_wdata;
	logic [1:0]                lookup_status;
	logic                      out_free;
	logic                      check_ok;
	rsp_t                      result;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign req_pri   = req.data.location[SLOT_SHIFT+SEC_INDEX_BITS +: PRI_INDEX_BITS];

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Split the captured slot address into trie indexes
	assign pri = item_q.location[SLOT_SHIFT+SEC_INDEX_BITS +: PRI_INDEX_BITS];
	assign sec = item_q.location[SLOT_SHIFT +: SEC_INDEX_BITS];

	// Resolve the mapping; a first store takes the next pool table in order
	assign mapped    = pri_valid_q[pri];
	assign pool_free = tables_used_q < USED_BITS'(POOL_TABLES);
	assign is_store  = (item_q.op == OP_STORE);
	assign alloc     = (state_q == S_LOOKUP) && is_store && !mapped && pool_free;
	assign tbl       = mapped ? pri_rd_q : tables_used_q[TBL_BITS-1:0];

	always_comb begin
		lookup_status = ST_OK;
		unique case (item_q.op)
			OP_STORE: begin
				if (!mapped && !pool_free) begin
					lookup_status = ST_POOL_EMPTY;
				end
			end
			OP_LOAD: begin
				if (!mapped) begin
					lookup_status = ST_UNMAPPED;
				end
			end
			default: begin
				lookup_status = ST_OK;
			end
		endcase
	end

	// Metadata port: the clearing sweep owns it until the sweep ends
	always_comb begin
		meta_we    = 1'b0;
		meta_re    = 1'b0;
		meta_addr  = clr_cnt_q;
		meta_wdata = '0;
		if (state_q == S_CLEAR) begin
			meta_we = 1'b1;
		end else if (state_q == S_LOOKUP) begin
			meta_addr  = META_ADDR_BITS'({tbl, sec});
			meta_wdata = {item_q.upper_bound, item_q.lower_bound};
			meta_we    = is_store && (mapped || pool_free);
			meta_re    = (item_q.op == OP_LOAD) && mapped;
		end
	end

	// Bounds check, second half: size must fit below bound - pointer
	assign check_ok = ge_lo_q && !diff_q[ADDR_BITS]
		&& ({{(ADDR_BITS-SIZE_BITS){1'b0}}, item_q.access_size} < diff_q[ADDR_BITS-1:0]);

	always_comb begin
		result = '0;
		result.status = status_q;
		unique case (item_q.op)
			OP_LOAD: begin
				if (status_q == ST_OK) begin
					result.found_lower = meta_rd_q[ADDR_BITS-1:0];
					result.found_upper = meta_rd_q[2*ADDR_BITS-1:ADDR_BITS];
				end
			end
			OP_CHECK: begin
				result.in_bounds = check_ok;
			end
			default: begin
				result.in_bounds = 1'b0;
			end
		endcase
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	// Sequencer, allocation state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_cnt_q     <= '0;
			tables_used_q <= '0;
			pri_valid_q   <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_data_q    <= '0;
		end else begin
			// Drop the result once it transfers, unless the finish step reloads it
			if (rsp_valid_q && rsp.ready && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == META_ADDR_BITS'(META_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_xfer) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (alloc) begin
						pri_valid_q[pri] <= 1'b1;
						tables_used_q    <= tables_used_q + 1'b1;
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// Hold until the output register can take the result
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_data_q  <= result;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and lookup results
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			item_q <= req.data;
		end
		if (state_q == S_LOOKUP) begin
			status_q <= lookup_status;
			ge_lo_q  <= item_q.pointer >= item_q.lower_bound;
			diff_q   <= {1'b0, item_q.upper_bound} - {1'b0, item_q.pointer};
		end
	end

	// Primary memory: read at transfer, write on allocation
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			pri_rd_q <= pri_mem[req_pri];
		end
		if (alloc) begin
			pri_mem[pri] <= tables_used_q[TBL_BITS-1:0];
		end
	end

	// Metadata memory: one port, read data registered
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_addr] <= meta_wdata;
		end
		if (meta_re) begin
			meta_rd_q <= meta_mem[meta_addr];
		end
	end

	// Pool use never passes its size
	a_pool_limit: assert property (@(posedge clk) disable iff (!arst_n)
		tables_used_q <= USED_BITS'(POOL_TABLES))
		else $error("pool use count beyond pool size");

	// No request transfers during the clearing sweep
	a_no_xfer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !req.ready)
		else $error("request ready during clearing sweep");

	// A new result appears only from the finish step
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result without finished operation");

	// Allocation takes exactly one pool table and marks the entry
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |=> (tables_used_q == $past(tables_used_q) + 1'b1) && pri_valid_q[$past(pri)])
		else $error("allocation did not advance pool use");

	// A waiting result is never overwritten before its transfer
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rsp_data_q))
		else $error("pending result changed");

endmodule

[tb/tb_pointer_bounds_metadata_table.sv]
// ----------------------------------------------------------------------------
// tb_pointer_bounds_metadata_table
// Self-checking bench for the two-level pointer bounds metadata table.
// ----------------------------------------------------------------------------
// Operations go in over the request channel and results come back over the
// response channel. A shadow copy of the trie (primary map, pool counter and
// base/bound store) predicts the result of every request at its transfer
// edge. The response process compares every result with the oldest
// prediction. Directed tests cover the field extremes, every op code, pool
// exhaustion and the bounds check corners. Random traffic then runs under
// four idling mixes: none, sender idle, receiver stalling, and both.
// ----------------------------------------------------------------------------
module tb_pointer_bounds_metadata_table;
	import pbmt_pkg::*;

	// Op code 3 has no member in op_t; the block must answer it with zeros.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n;

	pbmt_req_if req_ch ();
	pbmt_rsp_if rsp_ch ();

	pointer_bounds_metadata_table dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow trie state, updated in transfer order.
	bit          pri_mapped [PRI_ENTRIES];
	int unsigned pri_table  [PRI_ENTRIES];
	int unsigned tables_taken;
	bit [31:0]   meta_lower [META_DEPTH];
	bit [31:0]   meta_upper [META_DEPTH];
	int unsigned mapped_pri [$];

	rsp_t expected_meta_q [$];
	int   error_count;
	int   send_idle_pct;
	int   recv_stall_pct;

	// ------------------------------------------------------------------------
	// Prediction: apply one accepted request to the shadow trie and queue the
	// result the block must return for it.
	// ------------------------------------------------------------------------
	task automatic trie_predict(input req_t item);
		rsp_t                      r;
		logic [PRI_INDEX_BITS-1:0] pri;
		logic [SEC_INDEX_BITS-1:0] sec;
		int unsigned               slot;
		r   = '0;
		pri = item.location[SLOT_SHIFT+SEC_INDEX_BITS +: PRI_INDEX_BITS];
		sec = item.location[SLOT_SHIFT +: SEC_INDEX_BITS];
		case (item.op)
			OP_STORE: begin
				if (!pri_mapped[pri]) begin
					if (tables_taken >= POOL_TABLES) begin
						// pool exhausted: nothing mapped, nothing written
						r.status = ST_POOL_EMPTY;
					end else begin
						pri_table[pri]  = tables_taken;
						pri_mapped[pri] = 1'b1;
						tables_taken++;
						mapped_pri.push_back(32'(pri));
					end
				end
				if (r.status == ST_OK) begin
					slot = (pri_table[pri] % POOL_TABLES) * SEC_ENTRIES + sec;
					meta_lower[slot] = item.lower_bound;
					meta_upper[slot] = item.upper_bound;
				end
			end
			OP_LOAD: begin
				if (!pri_mapped[pri]) begin
					r.status = ST_UNMAPPED;
				end else begin
					slot = (pri_table[pri] % POOL_TABLES) * SEC_ENTRIES + sec;
					r.found_lower = meta_lower[slot];
					r.found_upper = meta_upper[slot];
				end
			end
			OP_CHECK: begin
				// exact compare in 33 bits, no wrap of pointer + size
				r.in_bounds = (item.pointer >= item.lower_bound) &&
					(({1'b0, item.pointer} + item.access_size) < {1'b0, item.upper_bound});
			end
			default: begin
				// unused op: all fields stay zero
			end
		endcase
		expected_meta_q.push_back(r);
	endtask

	function automatic logic [LOC_BITS-1:0] slot_loc(input int unsigned pri,
		input int unsigned sec, input int unsigned low);
		logic [PRI_INDEX_BITS-1:0] p;
		logic [SEC_INDEX_BITS-1:0] s;
		logic [SLOT_SHIFT-1:0]     l;
		p = PRI_INDEX_BITS'(pri);
		s = SEC_INDEX_BITS'(sec);
		l = SLOT_SHIFT'(low);
		return {p, s, l};
	endfunction

	function automatic req_t make_req(input logic [1:0] op, input logic [LOC_BITS-1:0] loc,
		input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] ptr,
		input logic [15:0] size);
		req_t r;
		r.op          = op;
		r.location    = loc;
		r.lower_bound = lo;
		r.upper_bound = hi;
		r.pointer     = ptr;
		r.access_size = size;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Send one request. Enter and leave at a falling edge; hold valid high
	// across back-to-back transfers so it is never dropped and raised in one
	// step.
	// ------------------------------------------------------------------------
	task automatic send_op(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data  = item;
		do @(posedge clk); while (!req_ch.ready);
		trie_predict(item);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response side: randomize ready at the falling edge, check at the rising
	// edge on every transfer.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (expected_meta_q.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected result: lower=%h upper=%h status=%0d in_bounds=%0b",
						got.found_lower, got.found_upper, got.status, got.in_bounds);
			end else begin
				want = expected_meta_q.pop_front();
				if (got.found_lower !== want.found_lower ||
					got.found_upper !== want.found_upper ||
					got.status !== want.status || got.in_bounds !== want.in_bounds) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display({"mismatch: expected lower=%h upper=%h status=%0d in_bounds=%0b,",
							" got lower=%h upper=%h status=%0d in_bounds=%0b"},
							want.found_lower, want.found_upper, want.status, want.in_bounds,
							got.found_lower, got.found_upper, got.status, got.in_bounds);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Store and load at the corners of the slot address: top primary entry
	// with full-range bounds (zero to all ones), primary entry zero with
	// inverted bounds, low slot bits ignored, and a mapped but never-written slot reading back zeros.
	task automatic test_store_load;
		send_op(make_req(OP_LOAD, slot_loc(0, 0, 0), '0, '0, '0, '0));
		send_op(make_req(OP_STORE, slot_loc(63, 1023, 7), 32'h0, 32'hFFFF_FFFF, '1, '1));
		send_op(make_req(OP_LOAD, slot_loc(63, 1023, 7), '0, '0, '0, '0));
		send_op(make_req(OP_LOAD, slot_loc(63, 1023, 0), '1, '1, '1, '1));
		send_op(make_req(OP_LOAD, slot_loc(63, 1022, 7), '0, '0, '0, '0));
		send_op(make_req(OP_STORE, slot_loc(0, 0, 0), 32'hFFFF_FFFF, 32'h0, '0, '0));
		send_op(make_req(OP_LOAD, slot_loc(0, 0, 5), '0, '0, '0, '0));
		// overwrite an existing slot
		send_op(make_req(OP_STORE, slot_loc(0, 0, 0), 32'hA5A5_5A5A, 32'h5A5A_A5A5, '0, '0));
		send_op(make_req(OP_LOAD, slot_loc(0, 0, 0), '0, '0, '0, '0));
	endtask

	// Fill the pool, then store to one more primary entry: it must fail and
	// leave that entry unmapped, while mapped entries still accept stores.
	task automatic test_pool_exhaustion;
		for (int p = 1; p <= 6; p++)
			send_op(make_req(OP_STORE, slot_loc(p, p * 100, 0), p, p << 20, '0, '0));
		send_op(make_req(OP_STORE, slot_loc(7, 5, 0), 32'h1234_5678, 32'h9ABC_DEF0, '0, '0));
		send_op(make_req(OP_LOAD, slot_loc(7, 5, 0), '0, '0, '0, '0));
		send_op(make_req(OP_STORE, slot_loc(63, 0, 0), 32'hDEAD_BEEF, 32'hFEED_F00D, '0, '0));
	endtask

	// Bounds check corners: below base, exact fit, touching the bound,
	// top of the address space, empty range.
	task automatic test_bounds_check;
		send_op(make_req(OP_CHECK, '0, 32'h1000, 32'h2000, 32'h0FFF, 16'd0));
		send_op(make_req(OP_CHECK, '0, 32'h1000, 32'h1001, 32'h1000, 16'd0));
		send_op(make_req(OP_CHECK, '0, 32'h1000, 32'h2000, 32'h1F00, 16'h0100));
		send_op(make_req(OP_CHECK, '0, 32'h1000, 32'h2000, 32'h1F00, 16'h00FF));
		send_op(make_req(OP_CHECK, '1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
		send_op(make_req(OP_CHECK, '1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_0000, 16'hFFFE));
		send_op(make_req(OP_CHECK, '0, 32'h0, 32'h0, 32'h0, 16'h0));
	endtask

	task automatic test_unused_op;
		send_op(make_req(OP_UNUSED, slot_loc(63, 1023, 7), '1, '1, '1, '1));
	endtask

	// Mostly mapped primary entries and a small set of slots so loads hit
	// earlier stores; the rest roams the whole address space.
	task automatic test_random_traffic(input int count, input int idle_pct,
		input int stall_pct);
		req_t        item;
		int unsigned pick;
		int unsigned pri;
		int unsigned sec;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 35)
				item.op = OP_STORE;
			else if (pick < 70)
				item.op = OP_LOAD;
			else if (pick < 95)
				item.op = OP_CHECK;
			else
				item.op = OP_UNUSED;
			if (mapped_pri.size() != 0 && $urandom_range(99) < 80)
				pri = mapped_pri[$urandom_range(mapped_pri.size() - 1)];
			else
				pri = $urandom;
			sec = $urandom_range(1) ? $urandom_range(15) : $urandom;
			item.location    = slot_loc(pri, sec, $urandom);
			item.lower_bound = $urandom;
			if ($urandom_range(1)) begin
				// pointer near a narrow range so both outcomes show up
				item.upper_bound = item.lower_bound + $urandom_range(4096);
				item.pointer     = item.lower_bound + $urandom_range(4200) - 64;
				item.access_size = SIZE_BITS'($urandom_range(256));
			end else begin
				item.upper_bound = $urandom;
				item.pointer     = $urandom;
				item.access_size = SIZE_BITS'($urandom_range(65535));
			end
			send_op(item);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.data    = '0;
		rsp_ch.ready   = 1'b0;
		error_count    = 0;
		tables_taken   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The clearing sweep holds req.ready low; send_op waits it out.
		test_store_load();
		test_pool_exhaustion();
		test_bounds_check();
		test_unused_op();

		test_random_traffic(410, 0, 0);
		test_random_traffic(405, 84, 0);
		test_random_traffic(405, 0, 84);
		test_random_traffic(405, 25, 25);

		req_ch.valid  = 1'b0;
		send_idle_pct = 0;
		while (expected_meta_q.size() != 0)
			@(posedge clk);
		// drain: wait on so that any stray result still shows up
		repeat (12) @(posedge clk);
		if (expected_meta_q.size() != 0)
			error_count++;

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hang guard: far beyond the clearing sweep plus worst-case traffic.
	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
src/pbmt_pkg.sv
src/pbmt_req_if.sv
src/pbmt_rsp_if.sv
src/pointer_bounds_metadata_table.sv
tb/tb_pointer_bounds_metadata_table.sv
